// ===== design/bbct_pkg.sv =====
package bbct_pkg;

    typedef enum logic [1:0] {
        CMD_GET   = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_DUP   = 2'd2,
        CMD_REL   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_FREE = 2'd1,
        ST_REL_0   = 2'd2,
        ST_SAT     = 2'd3
    } t_status;

    localparam logic [7:0] REF_MAX = 8'd255;

    typedef struct packed {
        t_cmd        cmd;
        logic [31:0] block_number;
        logic [3:0]  slot;
        logic        in_range;
    } t_job;

    typedef struct packed {
        logic [3:0] result_slot;
        logic       hit;
        logic       need_disk_read;
        logic       need_disk_write;
        logic [7:0] ref_after;
        t_status    status;
    } t_result;

endpackage

// ===== design/bbct_req_if.sv =====
interface bbct_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [31:0] block_number;
    logic [3:0]  slot;

    modport source (output valid, output cmd, output block_number, output slot, input ready);
    modport sink (input valid, input cmd, input block_number, input slot, output ready);
endinterface

// ===== design/bbct_rsp_if.sv =====
interface bbct_rsp_if;
    logic       valid;
    logic       ready;
    logic [3:0] result_slot;
    logic       hit;
    logic       need_disk_read;
    logic       need_disk_write;
    logic [7:0] ref_after;
    logic [1:0] status;

    modport source (
        output valid, output result_slot, output hit, output need_disk_read,
        output need_disk_write, output ref_after, output status, input ready
    );
    modport sink (
        input valid, input result_slot, input hit, input need_disk_read,
        input need_disk_write, input ref_after, input status, output ready
    );
endinterface

// ===== design/bbct_front.sv =====
module bbct_front #(
    parameter int ENTRIES = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [1:0]    i_cmd,
    input  logic [31:0]   i_block_number,
    input  logic [3:0]    i_slot,
    output logic          o_job_valid,
    input  logic          i_job_ready,
    output bbct_pkg::t_job o_job
);
    import bbct_pkg::*;

    t_job       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;
    t_job       job_in;

    always_comb begin
        job_in.cmd          = t_cmd'(i_cmd);
        job_in.block_number = i_block_number;
        job_in.slot         = i_slot;
        job_in.in_range     = (32'(i_slot) < 32'(ENTRIES));
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign push        = i_valid && o_ready;
    assign o_job_valid = (r_cnt != 2'd0);
    assign pop         = o_job_valid && i_job_ready;
    assign o_job       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= job_in;
    end

endmodule

// ===== design/bbct_back.sv =====
module bbct_back #(
    parameter int ENTRIES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    output logic              o_job_ready,
    input  bbct_pkg::t_job    i_job,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output bbct_pkg::t_result o_res
);
    import bbct_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    typedef enum logic [1:0] {
        S_LOOK = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state  r_state, n_state;
    t_job    r_job;
    logic [ENTRIES-1:0] r_hitv, r_freev;
    logic [31:0] r_tag [ENTRIES];
    logic [7:0]  r_ref [ENTRIES];
    logic [ENTRIES-1:0] r_vld;
    logic    r_ovld;
    t_result r_res;

    logic          pop, do_exec;
    logic          hit_any, free_any;
    logic [IW-1:0] hit_idx, free_idx, idx;
    logic          sel_ok;
    logic [7:0]    cur_ref;
    logic          cur_vld;
    logic          wr_en, tag_we;
    logic [7:0]    n_ref_e;
    logic          n_vld_e;
    logic [31:0]   n_tag_e;
    t_result       n_res;

    assign o_job_ready = (r_state == S_LOOK);
    assign pop         = i_job_valid && o_job_ready;
    assign do_exec     = (r_state == S_EXEC) && (!r_ovld || i_res_ready);

    always_comb begin
        unique case (r_state)
            S_LOOK:  n_state = pop ? S_EXEC : S_LOOK;
            S_EXEC:  n_state = do_exec ? S_LOOK : S_EXEC;
            default: n_state = S_LOOK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_LOOK;
        else r_state <= n_state;
    end

    // match and free vectors against the stable table
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_job <= i_job;
            for (int i = 0; i < ENTRIES; i++) begin
                r_hitv[i]  <= (r_ref[i] != 8'd0) && (r_tag[i] == i_job.block_number);
                r_freev[i] <= (r_ref[i] == 8'd0);
            end
        end
    end

    // lowest set bit wins
    always_comb begin
        hit_any  = 1'b0;
        free_any = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (r_hitv[i]) begin
                hit_any = 1'b1;
                hit_idx = IW'(i);
            end
            if (r_freev[i]) begin
                free_any = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    always_comb begin
        if (r_job.cmd == CMD_GET) begin
            idx    = hit_any ? hit_idx : free_idx;
            sel_ok = hit_any || free_any;
        end else begin
            idx    = IW'(r_job.slot);
            sel_ok = r_job.in_range;
        end
    end

    assign cur_ref = r_ref[idx];
    assign cur_vld = r_vld[idx];

    always_comb begin
        n_res   = '0;
        wr_en   = 1'b0;
        tag_we  = 1'b0;
        n_ref_e = cur_ref;
        n_vld_e = cur_vld;
        n_tag_e = r_job.block_number;
        case (r_job.cmd)
            CMD_GET: begin
                if (sel_ok) begin
                    wr_en                = 1'b1;
                    n_vld_e              = 1'b1;
                    n_res.result_slot    = 4'(idx);
                    n_res.need_disk_read = !cur_vld;
                    if (hit_any) begin
                        n_res.hit       = 1'b1;
                        n_res.ref_after = cur_ref;
                    end else begin
                        tag_we          = 1'b1;
                        n_ref_e         = 8'd1;
                        n_res.ref_after = 8'd1;
                    end
                end else begin
                    n_res.status = ST_NO_FREE;
                end
            end
            CMD_WRITE: begin
                n_res.result_slot = r_job.slot;
                if (sel_ok) begin
                    wr_en                 = 1'b1;
                    n_vld_e               = 1'b1;
                    n_res.need_disk_write = 1'b1;
                    n_res.ref_after       = cur_ref;
                end
            end
            CMD_DUP: begin
                n_res.result_slot = r_job.slot;
                if (sel_ok) begin
                    if (cur_ref == REF_MAX) begin
                        n_res.status = ST_SAT;
                    end else begin
                        wr_en   = 1'b1;
                        n_ref_e = cur_ref + 8'd1;
                    end
                    n_res.ref_after = n_ref_e;
                end
            end
            default: begin
                n_res.result_slot = r_job.slot;
                if (sel_ok) begin
                    if (cur_ref == 8'd0) begin
                        n_res.status = ST_REL_0;
                    end else begin
                        wr_en   = 1'b1;
                        n_ref_e = cur_ref - 8'd1;
                        if (n_ref_e == 8'd0) begin
                            n_vld_e = 1'b0;
                            tag_we  = 1'b1;
                            n_tag_e = '0;
                        end
                    end
                    n_res.ref_after = n_ref_e;
                end
            end
        endcase
    end

    // a get that claims a free entry loads its tag; the last release clears the tag back to zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) r_tag[i] <= '0;
        end else if (do_exec && tag_we) begin
            r_tag[idx] <= n_tag_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) r_ref[i] <= 8'd0;
            r_vld <= '0;
        end else if (do_exec && wr_en) begin
            r_ref[idx] <= n_ref_e;
            r_vld[idx] <= n_vld_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (do_exec) begin
            r_ovld <= 1'b1;
        end else if (i_res_ready) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_exec) r_res <= n_res;
    end

    assign o_res_valid = r_ovld;
    assign o_res       = r_res;

endmodule

// ===== design/block_buffer_cache_table.sv =====
// Buffer cache bookkeeping table: get, write, dup and release beats enter a
// two-beat queue and are carried out one at a time by the back end: a look
// state compares every entry's tag and count in parallel, then an execute
// state picks the entry, updates it and loads the result register, waiting
// there while the result side stalls. No new beat is taken until the last one
// is executed. All tags, counts and valid marks clear in the reset cycle;
// there is no clearing pass. ENTRIES sets the table depth (1 to 16).
module block_buffer_cache_table #(
    parameter int ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bbct_req_if.sink    i_req,
    bbct_rsp_if.source  o_rsp
);
    import bbct_pkg::*;

    logic    job_valid, job_ready;
    t_job    job;
    t_result res;

    bbct_front #(.ENTRIES(ENTRIES)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_req.valid),
        .o_ready        (i_req.ready),
        .i_cmd          (i_req.cmd),
        .i_block_number (i_req.block_number),
        .i_slot         (i_req.slot),
        .o_job_valid    (job_valid),
        .i_job_ready    (job_ready),
        .o_job          (job)
    );

    bbct_back #(.ENTRIES(ENTRIES)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .o_job_ready (job_ready),
        .i_job       (job),
        .o_res_valid (o_rsp.valid),
        .i_res_ready (o_rsp.ready),
        .o_res       (res)
    );

    assign o_rsp.result_slot     = res.result_slot;
    assign o_rsp.hit             = res.hit;
    assign o_rsp.need_disk_read  = res.need_disk_read;
    assign o_rsp.need_disk_write = res.need_disk_write;
    assign o_rsp.ref_after       = res.ref_after;
    assign o_rsp.status          = res.status;

endmodule

// ===== design/bbct_checker.sv =====
module bbct_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       i_ready,
    input logic [3:0] i_result_slot,
    input logic       i_hit,
    input logic       i_need_disk_read,
    input logic       i_need_disk_write,
    input logic [7:0] i_ref_after,
    input logic [1:0] i_status
);
    import bbct_pkg::*;

    a_rst_clears_out: assert property (@(posedge i_clk) !i_rst_n |=> !i_valid)
        else $error("result valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable({i_result_slot, i_hit,
        i_need_disk_read, i_need_disk_write, i_ref_after, i_status}))
        else $error("stalled result beat changed");

    a_hit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_hit || i_need_disk_read) |->
        i_status == ST_OK && !i_need_disk_write && i_ref_after != 8'd0)
        else $error("get hit or read with bad fields");

    a_write_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_need_disk_write |->
        i_status == ST_OK && !i_hit && !i_need_disk_read)
        else $error("write beat with get fields");

    a_no_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_status == ST_NO_FREE |->
        i_result_slot == 4'd0 && i_ref_after == 8'd0 && !i_need_disk_write)
        else $error("table full result not cleared");

endmodule

bind block_buffer_cache_table bbct_checker u_bbct_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (o_rsp.valid),
    .i_ready           (o_rsp.ready),
    .i_result_slot     (o_rsp.result_slot),
    .i_hit             (o_rsp.hit),
    .i_need_disk_read  (o_rsp.need_disk_read),
    .i_need_disk_write (o_rsp.need_disk_write),
    .i_ref_after       (o_rsp.ref_after),
    .i_status          (o_rsp.status)
);

// ===== tb/cache_table_checker.sv =====
`timescale 1ns / 1ps

module cache_table_checker #(
    parameter int ENTRIES = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    bbct_req_if  req_mon,
    bbct_rsp_if  rsp_mon,
    output int   o_fail_count,
    output int   o_outstanding,
    output int   o_checked,
    output int   o_hits,
    output int   o_table_full,
    output int   o_saturated,
    output int   o_unref_release
);
    import bbct_pkg::*;

    logic [31:0] blk_tag    [ENTRIES];
    logic [7:0]  ref_cnt    [ENTRIES];
    logic        valid_mark [ENTRIES];

    t_result expected_results [$];

    int fail_count;
    int outstanding;
    int checked;
    int hits;
    int table_full;
    int saturated;
    int unref_release;

    assign o_fail_count    = fail_count;
    assign o_outstanding   = outstanding;
    assign o_checked       = checked;
    assign o_hits          = hits;
    assign o_table_full    = table_full;
    assign o_saturated     = saturated;
    assign o_unref_release = unref_release;

    function automatic string fmt_res(t_result r);
        return $sformatf("slot %0d hit %0b rd %0b wr %0b ref %0d st %0d",
                         r.result_slot, r.hit, r.need_disk_read,
                         r.need_disk_write, r.ref_after, r.status);
    endfunction

    function automatic t_result predict_table_op(t_cmd c, logic [31:0] bno, logic [3:0] s);
        t_result r;
        bit      found;
        int      idx;
        r     = '0;
        found = 1'b0;
        idx   = 0;
        if (c == CMD_GET) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (!found && ref_cnt[i] != 8'd0 && blk_tag[i] == bno) begin
                    found = 1'b1;
                    idx   = i;
                    r.hit = 1'b1;
                end
            end
            for (int i = 0; i < ENTRIES; i++) begin
                if (!found && ref_cnt[i] == 8'd0) begin
                    found      = 1'b1;
                    idx        = i;
                    ref_cnt[i] = 8'd1;
                    blk_tag[i] = bno;
                end
            end
            if (found) begin
                r.need_disk_read = !valid_mark[idx];
                valid_mark[idx]  = 1'b1;
                r.result_slot    = 4'(idx);
                r.ref_after      = ref_cnt[idx];
            end else begin
                r.status = ST_NO_FREE;
            end
        end else begin
            r.result_slot = s;
            if (int'(s) < ENTRIES) begin
                case (c)
                    CMD_WRITE: begin
                        valid_mark[s]     = 1'b1;
                        r.need_disk_write = 1'b1;
                    end
                    CMD_DUP: begin
                        if (ref_cnt[s] == REF_MAX) begin
                            r.status = ST_SAT;
                        end else begin
                            ref_cnt[s] = ref_cnt[s] + 8'd1;
                        end
                    end
                    default: begin
                        if (ref_cnt[s] == 8'd0) begin
                            r.status = ST_REL_0;
                        end else begin
                            ref_cnt[s] = ref_cnt[s] - 8'd1;
                            if (ref_cnt[s] == 8'd0) begin
                                blk_tag[s]    = '0;
                                valid_mark[s] = 1'b0;
                            end
                        end
                    end
                endcase
                r.ref_after = ref_cnt[s];
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                blk_tag[i]    = '0;
                ref_cnt[i]    = '0;
                valid_mark[i] = 1'b0;
            end
            expected_results.delete();
            outstanding   = 0;
            fail_count    = 0;
            checked       = 0;
            hits          = 0;
            table_full    = 0;
            saturated     = 0;
            unref_release = 0;
        end else begin
            if (req_mon.valid && req_mon.ready) begin
                want = predict_table_op(t_cmd'(req_mon.cmd), req_mon.block_number,
                                        req_mon.slot);
                expected_results.push_back(want);
            end
            if (rsp_mon.valid && rsp_mon.ready) begin
                got.result_slot     = rsp_mon.result_slot;
                got.hit             = rsp_mon.hit;
                got.need_disk_read  = rsp_mon.need_disk_read;
                got.need_disk_write = rsp_mon.need_disk_write;
                got.ref_after       = rsp_mon.ref_after;
                got.status          = t_status'(rsp_mon.status);
                if (expected_results.size() == 0) begin
                    if (fail_count < 10) begin
                        $display("unexpected response beat: %s", fmt_res(got));
                    end
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    checked++;
                    if (want.hit) hits++;
                    if (want.status == ST_NO_FREE) table_full++;
                    if (want.status == ST_SAT) saturated++;
                    if (want.status == ST_REL_0) unref_release++;
                    if (got.result_slot !== want.result_slot ||
                        got.hit !== want.hit ||
                        got.need_disk_read !== want.need_disk_read ||
                        got.need_disk_write !== want.need_disk_write ||
                        got.ref_after !== want.ref_after ||
                        got.status !== want.status) begin
                        if (fail_count < 10) begin
                            $display("mismatch on response %0d: expected %s",
                                     checked, fmt_res(want));
                            $display("    actual %s", fmt_res(got));
                        end
                        fail_count++;
                    end
                end
            end
            outstanding = expected_results.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import bbct_pkg::*;

    localparam int ENTRIES     = 16;
    localparam int ITEMS       = 1400;
    localparam int CALM_ITEMS  = 150;
    localparam int HOLD_AT     = 500;
    localparam int HOLD_CYCLES = 80;
    localparam int LIMIT       = 300000;

    logic i_clk;
    logic i_rst_n;

    bbct_req_if req_bus();
    bbct_rsp_if rsp_bus();

    int fail_count;
    int outstanding;
    int checked;
    int hits;
    int table_full;
    int saturated;
    int unref_release;

    int cycle_count;
    int input_stall_cycles;
    int sent_count;
    bit calm;
    bit hold_done;

    logic [31:0] block_pool [8];

    block_buffer_cache_table #(.ENTRIES(ENTRIES)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    cache_table_checker #(.ENTRIES(ENTRIES)) checker_inst (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .req_mon         (req_bus),
        .rsp_mon         (rsp_bus),
        .o_fail_count    (fail_count),
        .o_outstanding   (outstanding),
        .o_checked       (checked),
        .o_hits          (hits),
        .o_table_full    (table_full),
        .o_saturated     (saturated),
        .o_unref_release (unref_release)
    );

    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (req_bus.valid && !req_bus.ready) begin
            input_stall_cycles <= input_stall_cycles + 1;
        end
        if (cycle_count >= LIMIT) begin
            $display("timeout after %0d cycles, %0d responses outstanding", cycle_count, outstanding);
            $display("status: fail");
            $finish;
        end
    end

    // response side: short random stalls plus one long hold-off
    initial begin
        int stall_left;
        int hold_left;
        stall_left    = 0;
        hold_left     = 0;
        hold_done     = 1'b0;
        rsp_bus.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                rsp_bus.ready <= 1'b0;
            end else if (!hold_done && sent_count >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                rsp_bus.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rsp_bus.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 2);
                rsp_bus.ready <= 1'b0;
            end else begin
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    task automatic send_op(t_cmd c, logic [31:0] bno, logic [3:0] s);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 3);
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_bus.valid        <= 1'b1;
        req_bus.cmd          <= c;
        req_bus.block_number <= bno;
        req_bus.slot         <= s;
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
        sent_count++;
        calm = (sent_count >= ITEMS - CALM_ITEMS);
    endtask

    task automatic send_random_op();
        t_cmd        c;
        logic [31:0] bno;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 35) c = CMD_GET;
        else if (pick < 50) c = CMD_WRITE;
        else if (pick < 65) c = CMD_DUP;
        else c = CMD_REL;
        bno = ($urandom_range(0, 9) < 7) ? block_pool[$urandom_range(0, 7)] : $urandom();
        send_op(c, bno, 4'($urandom_range(0, 15)));
    endtask

    // claim every entry with fresh blocks, overflow, then let go of them
    task automatic fill_table();
        int extra;
        extra = $urandom_range(1, 3);
        for (int i = 0; i < ENTRIES + extra; i++) begin
            send_op(CMD_GET, $urandom(), 4'($urandom_range(0, 15)));
        end
        for (int i = 0; i < ENTRIES; i++) begin
            if ($urandom_range(0, 3) == 0) send_op(CMD_WRITE, $urandom(), 4'(i));
            send_op(CMD_REL, $urandom(), 4'(i));
        end
    endtask

    task automatic release_sweep();
        for (int i = 0; i < ENTRIES; i++) begin
            send_op(CMD_REL, $urandom(), 4'(i));
        end
    endtask

    // count up past the ceiling, then back down past zero
    task automatic saturate_slot(logic [3:0] s);
        for (int i = 0; i < 258; i++) send_op(CMD_DUP, $urandom(), s);
        for (int i = 0; i < 257; i++) send_op(CMD_REL, $urandom(), s);
    endtask

    initial begin
        int pick;
        block_pool[0] = 32'h0000_0000;
        block_pool[1] = 32'hFFFF_FFFF;
        block_pool[2] = 32'h0000_0001;
        block_pool[3] = 32'h8000_0000;
        block_pool[4] = 32'h5A5A_A5A5;
        block_pool[5] = 32'h0000_0100;
        block_pool[6] = 32'h7FFF_FFFF;
        block_pool[7] = 32'h0001_2345;

        cycle_count          = 0;
        input_stall_cycles   = 0;
        sent_count           = 0;
        calm                 = 1'b0;
        i_rst_n              = 1'b0;
        req_bus.valid        = 1'b0;
        req_bus.cmd          = CMD_GET;
        req_bus.block_number = '0;
        req_bus.slot         = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_op(CMD_GET,   32'h0000_0000, 4'd0);
        send_op(CMD_GET,   32'h0000_0000, 4'd9);
        send_op(CMD_GET,   32'hFFFF_FFFF, 4'd15);
        send_op(CMD_WRITE, 32'h0000_0000, 4'd1);
        send_op(CMD_WRITE, 32'hFFFF_FFFF, 4'd15);
        send_op(CMD_DUP,   32'h0000_0000, 4'd0);
        send_op(CMD_REL,   32'h0000_0000, 4'd0);
        send_op(CMD_REL,   32'h0000_0000, 4'd0);
        send_op(CMD_REL,   32'h0000_0000, 4'd0);
        send_op(CMD_GET,   32'h0000_0000, 4'd0);
        send_op(CMD_DUP,   32'h0000_0000, 4'd15);
        send_op(CMD_GET,   32'h5A5A_A5A5, 4'd0);
        send_op(CMD_REL,   32'h0000_0000, 4'd15);
        send_op(CMD_GET,   32'h8000_0001, 4'd0);
        send_op(CMD_WRITE, 32'h0000_0000, 4'd3);
        send_op(CMD_DUP,   32'h0000_0000, 4'd3);
        send_op(CMD_GET,   32'h8000_0001, 4'd0);
        send_op(CMD_REL,   32'h0000_0000, 4'd1);
        send_op(CMD_REL,   32'h0000_0000, 4'd2);
        send_op(CMD_REL,   32'h0000_0000, 4'd3);
        send_op(CMD_REL,   32'h0000_0000, 4'd3);
        send_op(CMD_REL,   32'h0000_0000, 4'd0);

        fill_table();
        saturate_slot(4'($urandom_range(0, 15)));

        while (sent_count < ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 3) fill_table();
            else if (pick < 8) release_sweep();
            else send_random_op();
        end

        req_bus.valid <= 1'b0;
        while (outstanding != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("checked %0d response beats over %0d request beats: %0d hits, %0d table full",
                 checked, sent_count, hits, table_full);
        $display("%0d saturated dups, %0d unreferenced releases, input stalled %0d cycles",
                 saturated, unref_release, input_stall_cycles);
        if (fail_count == 0 && outstanding == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== block_buffer_cache_table.f =====
design/bbct_pkg.sv
design/bbct_req_if.sv
design/bbct_rsp_if.sv
design/bbct_front.sv
design/bbct_back.sv
design/block_buffer_cache_table.sv
design/bbct_checker.sv
tb/cache_table_checker.sv
tb/testbench.sv
